>>> design/pidd_pkg.sv
package pidd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int NUM_DEVICES_DEF = 3;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [1:0] DEV_DISK    = 2'd0;
  localparam logic [1:0] DEV_NETWORK = 2'd1;
  localparam logic [1:0] DEV_PRINTER = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [15:0] proc_id;
    logic [7:0]  urgency;
    logic [1:0]  device_sel;
    logic [15:0] busy_ticks;
  } in_word_t;

  typedef struct packed {
    logic        dispatched;
    logic [15:0] dispatched_pid;
    logic [1:0]  dispatched_device;
    logic [1:0]  finished_now;
    logic        rejected_full;
    logic [4:0]  pending_count;
    logic [31:0] completed_total;
    logic [31:0] accepted_total;
    logic [31:0] elapsed_ticks;
  } out_word_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  urgency;
    logic [1:0]  dev;
    logic [15:0] dur;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic res_valid;
  } ctrl_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

>>> design/pidd_ram.sv
module pidd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/pidd_ctrl.sv
module pidd_ctrl #(
  parameter int QUEUE_DEPTH = pidd_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_DEVICES = pidd_pkg::NUM_DEVICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             take,
  input  pidd_pkg::in_word_t               item,
  input  logic                             out_free,
  output pidd_pkg::ctrl_stat_t             stat,
  output pidd_pkg::out_word_t              res,
  output logic                             mem_wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_wr_addr,
  output pidd_pkg::entry_t                 mem_wr_data,
  output logic [$clog2(QUEUE_DEPTH)-1:0]   mem_rd_addr,
  input  pidd_pkg::entry_t                 mem_rd_data
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int FIN_W  = $clog2(NUM_DEVICES + 1);

  pidd_pkg::state_t state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0]  sp_r, sp_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  pidd_pkg::entry_t  best_r, best_nxt;
  logic [15:0]       timer_r [NUM_DEVICES];
  logic [15:0]       timer_nxt [NUM_DEVICES];
  logic [15:0]       timer_dec [NUM_DEVICES];
  logic [FIN_W-1:0]  fin_cnt;
  logic              head_free;
  logic [31:0]       done_r, done_nxt;
  logic [31:0]       acc_r, acc_nxt;
  logic [31:0]       tick_r, tick_nxt;
  logic              disp_r, disp_nxt;
  logic [15:0]       dpid_r, dpid_nxt;
  logic [1:0]        ddev_r, ddev_nxt;
  logic [1:0]        fin_r, fin_nxt;
  logic              rej_r, rej_nxt;

  always_comb begin
    fin_cnt   = '0;
    head_free = 1'b0;
    for (int d = 0; d < NUM_DEVICES; d++) begin
      timer_dec[d] = timer_r[d];
      if (timer_r[d] != 16'd0) begin
        timer_dec[d] = timer_r[d] - 16'd1;
        if (timer_r[d] == 16'd1) begin
          fin_cnt = fin_cnt + 1'b1;
        end
      end
      if (int'(best_r.dev) == d && timer_r[d] == 16'd0) begin
        head_free = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    sp_nxt       = sp_r;
    best_idx_nxt = best_idx_r;
    best_nxt     = best_r;
    timer_nxt    = timer_r;
    done_nxt     = done_r;
    acc_nxt      = acc_r;
    tick_nxt     = tick_r;
    disp_nxt     = disp_r;
    dpid_nxt     = dpid_r;
    ddev_nxt     = ddev_r;
    fin_nxt      = fin_r;
    rej_nxt      = rej_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = IDX_W'(fill_r);
    mem_wr_data  = '{pid: item.proc_id, urgency: item.urgency,
                     dev: item.device_sel, dur: item.busy_ticks};
    mem_rd_addr  = sp_r;
    case (state_r)
      pidd_pkg::ST_IDLE: begin
        if (take) begin
          disp_nxt = 1'b0;
          dpid_nxt = '0;
          ddev_nxt = '0;
          fin_nxt  = '0;
          rej_nxt  = 1'b0;
          if (item.mode == pidd_pkg::MODE_ADD) begin
            if (int'(item.device_sel) < NUM_DEVICES) begin
              if (fill_r == FILL_W'(QUEUE_DEPTH)) begin
                rej_nxt = 1'b1;
              end else begin
                mem_wr_en = 1'b1;
                fill_nxt  = fill_r + 1'b1;
                acc_nxt   = acc_r + 32'd1;
              end
            end
            state_nxt = pidd_pkg::ST_DONE;
          end else begin
            tick_nxt  = tick_r + 32'd1;
            timer_nxt = timer_dec;
            done_nxt  = done_r + 32'(fin_cnt);
            fin_nxt   = (32'(fin_cnt) > 32'd3) ? 2'd3 : 2'(fin_cnt);
            if (fill_r == '0) begin
              state_nxt = pidd_pkg::ST_DONE;
            end else begin
              mem_rd_addr = '0;
              sp_nxt      = '0;
              state_nxt   = pidd_pkg::ST_SCAN;
            end
          end
        end
      end
      pidd_pkg::ST_SCAN: begin
        if (sp_r == '0 || mem_rd_data.urgency < best_r.urgency) begin
          best_nxt     = mem_rd_data;
          best_idx_nxt = sp_r;
        end
        if (FILL_W'(sp_r) == fill_r - 1'b1) begin
          state_nxt = pidd_pkg::ST_DECIDE;
        end else begin
          mem_rd_addr = sp_r + 1'b1;
          sp_nxt      = sp_r + 1'b1;
        end
      end
      pidd_pkg::ST_DECIDE: begin
        state_nxt = pidd_pkg::ST_DONE;
        if (head_free) begin
          for (int d = 0; d < NUM_DEVICES; d++) begin
            if (int'(best_r.dev) == d) begin
              timer_nxt[d] = best_r.dur;
            end
          end
          disp_nxt = 1'b1;
          dpid_nxt = best_r.pid;
          ddev_nxt = best_r.dev;
          fill_nxt = fill_r - 1'b1;
          if (FILL_W'(best_idx_r) + 1'b1 < fill_r) begin
            mem_rd_addr = best_idx_r + 1'b1;
            sp_nxt      = best_idx_r + 1'b1;
            state_nxt   = pidd_pkg::ST_SHIFT;
          end
        end
      end
      pidd_pkg::ST_SHIFT: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = sp_r - 1'b1;
        mem_wr_data = mem_rd_data;
        if (FILL_W'(sp_r) == fill_r) begin
          state_nxt = pidd_pkg::ST_DONE;
        end else begin
          mem_rd_addr = sp_r + 1'b1;
          sp_nxt      = sp_r + 1'b1;
        end
      end
      pidd_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = pidd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pidd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pidd_pkg::ST_IDLE;
      fill_r  <= '0;
      done_r  <= '0;
      acc_r   <= '0;
      tick_r  <= '0;
      for (int d = 0; d < NUM_DEVICES; d++) begin
        timer_r[d] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      done_r  <= done_nxt;
      acc_r   <= acc_nxt;
      tick_r  <= tick_nxt;
      timer_r <= timer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r       <= sp_nxt;
    best_idx_r <= best_idx_nxt;
    best_r     <= best_nxt;
    disp_r     <= disp_nxt;
    dpid_r     <= dpid_nxt;
    ddev_r     <= ddev_nxt;
    fin_r      <= fin_nxt;
    rej_r      <= rej_nxt;
  end

  assign stat.busy      = (state_r != pidd_pkg::ST_IDLE);
  assign stat.res_valid = (state_r == pidd_pkg::ST_DONE);

  assign res.dispatched        = disp_r;
  assign res.dispatched_pid    = dpid_r;
  assign res.dispatched_device = ddev_r;
  assign res.finished_now      = fin_r;
  assign res.rejected_full     = rej_r;
  assign res.pending_count     = 5'(fill_r);
  assign res.completed_total   = done_r;
  assign res.accepted_total    = acc_r;
  assign res.elapsed_ticks     = tick_r;

endmodule

>>> design/priority_io_device_dispatcher_unit.sv
// Priority I/O request dispatcher for up to NUM_DEVICES devices.
// Input channel (in_valid, in_stall, in_word): mode 0 queues a request
// (pid, urgency, device, busy ticks); mode 1 is one time tick that counts
// down busy devices and dispatches the queued request of lowest urgency
// value, earlier arrival first on equal urgency, when its device is free.
// Output channel (out_valid, out_stall, out_word): one word per input word,
// in order, with dispatch info, finish count, queue fill and totals.
// An add goes from IDLE to DONE, and leaves DONE for the output register
// once that register is free; the next word is then taken back in IDLE.
// A tick with requests pending goes from IDLE through SCAN and DECIDE,
// and through SHIFT when the dispatched slot was not the last, to DONE:
// the queue lives in one RAM with a single read port, scanned once for the
// head and then compacted one entry per cycle behind the dispatched slot.
// One word is worked on at a time; in_stall is high while it is in flight.
// A finished word waits in the output register while out_stall is high, and
// the next input word is still taken and worked up to its own result.
// Reset empties the queue, frees all devices and clears every total.
module priority_io_device_dispatcher_unit #(
  parameter int QUEUE_DEPTH = pidd_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_DEVICES = pidd_pkg::NUM_DEVICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pidd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pidd_pkg::out_word_t out_word
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  pidd_pkg::ctrl_stat_t stat;
  pidd_pkg::out_word_t  res;
  pidd_pkg::out_word_t  out_word_r;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic                 load;
  logic                 take;
  logic                 mem_wr_en;
  logic [IDX_W-1:0]     mem_wr_addr;
  logic [IDX_W-1:0]     mem_rd_addr;
  pidd_pkg::entry_t     mem_wr_data;
  pidd_pkg::entry_t     mem_rd_data;

  assign in_stall = stat.busy;
  assign take     = in_valid && !stat.busy;
  assign out_free = !out_valid_r || !out_stall;
  assign load     = stat.res_valid && out_free;

  pidd_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NUM_DEVICES(NUM_DEVICES)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (take),
    .item        (in_word),
    .out_free    (out_free),
    .stat        (stat),
    .res         (res),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  pidd_ram #(
    .WIDTH($bits(pidd_pkg::entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
